// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge
`define TCW_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that forces a consequence at the next edge
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tcw_pkg.sv =====
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int ATTR_W   = 8;
  localparam int OFS_W    = 11;
  localparam int SCROLL_W = 16;

  localparam logic [ATTR_W-1:0] COLOR_RESET = 8'd7;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_BOX   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUT_WRAP,
    ST_PUT_CHAR,
    ST_BS_WR,
    ST_PUT_END,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_SCR_FILL,
    ST_CLEAR,
    ST_BOX_INIT,
    ST_BOX_WR,
    ST_BOX_ROW,
    ST_RD_INIT,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_DONE
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col_a;
    logic [ROW_W-1:0]  row_a;
    logic [COL_W-1:0]  col_b;
    logic [ROW_W-1:0]  row_b;
    logic [ATTR_W-1:0] fill_color;
  } in_word_t;

  typedef struct packed {
    logic [COL_W-1:0]    cursor_col;
    logic [ROW_W-1:0]    cursor_row;
    logic [OFS_W-1:0]    cursor_offset;
    logic [CHAR_W-1:0]   read_char;
    logic [ATTR_W-1:0]   read_attr;
    logic [SCROLL_W-1:0] scroll_count;
  } out_word_t;

endpackage

// ===== rtl/core/tcw_ram.sv =====
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/text_console_writer_top.sv =====
// Put character: PUT_WRAP, PUT_CHAR, BS_WR if backspace blanks a cell, PUT_END; a tab puts four spaces.
// A scroll copies rows up (SCR_RD, SCR_WR) and blanks the last row (SCR_FILL); clear blanks every cell.
// Box fill writes cells in BOX_WR with a BOX_ROW step between rows; read cell skips the RAM off screen.
// One command at a time; the next is accepted the cycle after the result word is loaded.
// Synchronous active-high reset clears cursor, scroll count, color (to 7) and handshake;
// screen RAM content is undefined until the first clear.
module text_console_writer_top import tcw_pkg::*; #(
  parameter int COLS = COLS_DEF,
  parameter int ROWS = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              cfg_wen,
  input  logic [ATTR_W-1:0] cfg_wdata
);

  localparam int NCELLS = ROWS * COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int SW     = (AW + 1 > OFS_W) ? AW + 1 : OFS_W;
  localparam int CW     = $clog2(COLS + 1);
  localparam int LW     = $clog2(ROWS);
  localparam int CXW    = (CW > COL_W) ? CW : COL_W;
  localparam int RXW    = ($clog2(ROWS + 1) > ROW_W) ? $clog2(ROWS + 1) : ROW_W;

  state_t state, state_next;

  logic [CW-1:0]       col, col_next;
  logic [LW-1:0]       line, line_next;
  logic [AW-1:0]       base, base_next;
  logic [SCROLL_W-1:0] scrolled, scrolled_next;
  logic [ATTR_W-1:0]   color;
  logic [AW-1:0]       addr, addr_next;
  logic [AW-1:0]       rowbase, rowbase_next;
  logic [CXW-1:0]      bc, bc_next;
  logic [CXW-1:0]      cbc, cbc_next;
  logic [RXW-1:0]      br, br_next;
  logic [RXW-1:0]      rbc, rbc_next;
  logic [1:0]          rep, rep_next;
  logic [CHAR_W-1:0]   ch, ch_next;
  logic                scr_to_char, scr_to_char_next;
  logic [CHAR_W-1:0]   rd_char, rd_char_next;
  logic [ATTR_W-1:0]   rd_attr, rd_attr_next;
  in_word_t            in_q, in_q_next;
  logic                out_valid_next;
  out_word_t           out_word_next;

  // shared address adder
  logic [SW-1:0] add_a, add_b, sum;

  // box and read decode
  logic [CXW-1:0] ca_x, cb_clip;
  logic [RXW-1:0] ra_x, rb_clip;
  logic           box_empty, rd_in_range;

  // RAM ports
  logic              char_we, attr_we;
  logic [AW-1:0]     waddr, raddr;
  logic [CHAR_W-1:0] wchar, char_rdata;
  logic [ATTR_W-1:0] wattr, attr_rdata;

  tcw_ram #(.WIDTH(CHAR_W), .DEPTH(NCELLS)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (waddr),
    .wdata (wchar),
    .raddr (raddr),
    .rdata (char_rdata)
  );

  tcw_ram #(.WIDTH(ATTR_W), .DEPTH(NCELLS)) u_attr_ram (
    .clk   (clk),
    .we    (attr_we),
    .waddr (waddr),
    .wdata (wattr),
    .raddr (raddr),
    .rdata (attr_rdata)
  );

  assign in_stall = (state != ST_IDLE);
  assign sum      = add_a + add_b;

  assign ca_x        = CXW'(in_q.col_a);
  assign ra_x        = RXW'(in_q.row_a);
  assign cb_clip     = (CXW'(in_q.col_b) > CXW'(COLS)) ? CXW'(COLS) : CXW'(in_q.col_b);
  assign rb_clip     = (RXW'(in_q.row_b) > RXW'(ROWS)) ? RXW'(ROWS) : RXW'(in_q.row_b);
  assign box_empty   = (ca_x >= cb_clip) || (ra_x >= rb_clip);
  assign rd_in_range = (ca_x < CXW'(COLS)) && (ra_x < RXW'(ROWS));

  always_comb begin
    add_a = SW'(base);
    add_b = SW'(col);
    case (state)
      ST_PUT_WRAP: begin
        add_b = SW'(COLS);
      end
      ST_PUT_CHAR: begin
        if (ch == CH_LF) begin
          add_b = SW'(COLS);
        end else if (ch == CH_BS && col == '0) begin
          add_b = SW'(-COLS);
        end
      end
      ST_SCR_RD: begin
        add_a = SW'(addr);
        add_b = SW'(COLS);
      end
      ST_SCR_WR, ST_SCR_FILL, ST_CLEAR: begin
        add_a = SW'(addr);
        add_b = SW'(1);
      end
      ST_BOX_WR: begin
        add_a = SW'(rowbase);
        add_b = SW'(bc);
      end
      ST_BOX_ROW: begin
        add_a = SW'(rowbase);
        add_b = SW'(COLS);
      end
      ST_RD_ISSUE: begin
        add_a = SW'(rowbase);
        add_b = SW'(in_q.col_a);
      end
      default: begin
        add_a = SW'(base);
        add_b = SW'(col);
      end
    endcase
  end

  always_comb begin
    state_next       = state;
    col_next         = col;
    line_next        = line;
    base_next        = base;
    scrolled_next    = scrolled;
    addr_next        = addr;
    rowbase_next     = rowbase;
    bc_next          = bc;
    cbc_next         = cbc;
    br_next          = br;
    rbc_next         = rbc;
    rep_next         = rep;
    ch_next          = ch;
    scr_to_char_next = scr_to_char;
    rd_char_next     = rd_char;
    rd_attr_next     = rd_attr;
    in_q_next        = in_q;
    out_valid_next   = out_valid && out_stall;
    out_word_next    = out_word;
    char_we          = 1'b0;
    attr_we          = 1'b0;
    waddr            = sum[AW-1:0];
    raddr            = sum[AW-1:0];
    wchar            = CH_SPACE;
    wattr            = color;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          in_q_next    = in_word;
          rd_char_next = '0;
          rd_attr_next = '0;
          case (in_word.command)
            CMD_PUT: begin
              ch_next    = (in_word.char_code == CH_TAB) ? CH_SPACE : in_word.char_code;
              rep_next   = (in_word.char_code == CH_TAB) ? 2'd3 : 2'd0;
              state_next = ST_PUT_WRAP;
            end
            CMD_CLEAR: begin
              addr_next  = '0;
              state_next = ST_CLEAR;
            end
            CMD_BOX:  state_next = ST_BOX_INIT;
            CMD_READ: state_next = ST_RD_INIT;
            default:  state_next = ST_IDLE;
          endcase
        end
      end

      ST_PUT_WRAP: begin
        state_next = ST_PUT_CHAR;
        if (col == CW'(COLS)) begin
          if (line == LW'(ROWS - 1)) begin
            scr_to_char_next = 1'b1;
            addr_next        = '0;
            state_next       = ST_SCR_RD;
          end else begin
            line_next = line + 1'b1;
            base_next = sum[AW-1:0];
            col_next  = '0;
          end
        end
      end

      ST_PUT_CHAR: begin
        state_next = ST_PUT_END;
        case (ch)
          CH_LF: begin
            if (line == LW'(ROWS - 1)) begin
              scr_to_char_next = 1'b0;
              addr_next        = '0;
              state_next       = ST_SCR_RD;
            end else begin
              line_next = line + 1'b1;
              base_next = sum[AW-1:0];
              col_next  = '0;
            end
          end
          CH_NUL, CH_CR: begin
            state_next = ST_PUT_END;
          end
          CH_BS: begin
            if (col == '0) begin
              if (line != '0) begin
                line_next  = line - 1'b1;
                base_next  = sum[AW-1:0];
                col_next   = CW'(COLS - 1);
                state_next = ST_BS_WR;
              end
            end else begin
              col_next   = col - 1'b1;
              state_next = ST_BS_WR;
            end
          end
          default: begin
            char_we  = 1'b1;
            attr_we  = 1'b1;
            wchar    = ch;
            col_next = col + 1'b1;
          end
        endcase
      end

      ST_BS_WR: begin
        char_we    = 1'b1;
        attr_we    = 1'b1;
        state_next = ST_PUT_END;
      end

      ST_PUT_END: begin
        if (rep != '0) begin
          rep_next   = rep - 1'b1;
          state_next = ST_PUT_WRAP;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_SCR_RD: begin
        state_next = ST_SCR_WR;
      end

      ST_SCR_WR: begin
        char_we   = 1'b1;
        attr_we   = 1'b1;
        waddr     = addr;
        wchar     = char_rdata;
        wattr     = attr_rdata;
        addr_next = sum[AW-1:0];
        if (addr == AW'(NCELLS - COLS - 1)) begin
          state_next = ST_SCR_FILL;
        end else begin
          state_next = ST_SCR_RD;
        end
      end

      ST_SCR_FILL: begin
        char_we   = 1'b1;
        attr_we   = 1'b1;
        waddr     = addr;
        addr_next = sum[AW-1:0];
        if (addr == AW'(NCELLS - 1)) begin
          col_next      = '0;
          line_next     = LW'(ROWS - 1);
          base_next     = AW'((ROWS - 1) * COLS);
          scrolled_next = scrolled + 1'b1;
          state_next    = scr_to_char ? ST_PUT_CHAR : ST_PUT_END;
        end
      end

      ST_CLEAR: begin
        char_we   = 1'b1;
        attr_we   = 1'b1;
        waddr     = addr;
        addr_next = sum[AW-1:0];
        if (addr == AW'(NCELLS - 1)) begin
          col_next      = '0;
          line_next     = '0;
          base_next     = '0;
          scrolled_next = '0;
          state_next    = ST_DONE;
        end
      end

      ST_BOX_INIT: begin
        cbc_next     = cb_clip;
        rbc_next     = rb_clip;
        bc_next      = ca_x;
        br_next      = ra_x;
        rowbase_next = AW'(in_q.row_a * COLS);
        state_next   = box_empty ? ST_DONE : ST_BOX_WR;
      end

      ST_BOX_WR: begin
        attr_we = 1'b1;
        wattr   = in_q.fill_color;
        if (CXW'(bc + 1'b1) < cbc) begin
          bc_next = bc + 1'b1;
        end else begin
          bc_next = ca_x;
          if (RXW'(br + 1'b1) < rbc) begin
            br_next    = br + 1'b1;
            state_next = ST_BOX_ROW;
          end else begin
            state_next = ST_DONE;
          end
        end
      end

      ST_BOX_ROW: begin
        rowbase_next = sum[AW-1:0];
        state_next   = ST_BOX_WR;
      end

      ST_RD_INIT: begin
        rowbase_next = AW'(in_q.row_a * COLS);
        state_next   = rd_in_range ? ST_RD_ISSUE : ST_DONE;
      end

      ST_RD_ISSUE: begin
        state_next = ST_RD_DATA;
      end

      ST_RD_DATA: begin
        rd_char_next = char_rdata;
        rd_attr_next = attr_rdata;
        state_next   = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next              = 1'b1;
          out_word_next.cursor_col    = COL_W'(col);
          out_word_next.cursor_row    = ROW_W'(line);
          out_word_next.cursor_offset = sum[OFS_W-1:0];
          out_word_next.read_char     = rd_char;
          out_word_next.read_attr     = rd_attr;
          out_word_next.scroll_count  = scrolled;
          state_next                  = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      col       <= '0;
      line      <= '0;
      base      <= '0;
      scrolled  <= '0;
      color     <= COLOR_RESET;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      col       <= col_next;
      line      <= line_next;
      base      <= base_next;
      scrolled  <= scrolled_next;
      out_valid <= out_valid_next;
      if (cfg_wen) begin
        color <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr        <= addr_next;
    rowbase     <= rowbase_next;
    bc          <= bc_next;
    cbc         <= cbc_next;
    br          <= br_next;
    rbc         <= rbc_next;
    rep         <= rep_next;
    ch          <= ch_next;
    scr_to_char <= scr_to_char_next;
    rd_char     <= rd_char_next;
    rd_attr     <= rd_attr_next;
    in_q        <= in_q_next;
    out_word    <= out_word_next;
  end

`include "assert_macros.svh"

  `TCW_ASSERT_ALWAYS(a_col_range, col <= CW'(COLS), "cursor column past row end")
  `TCW_ASSERT_ALWAYS(a_line_range, line <= LW'(ROWS - 1), "cursor row past last row")
  `TCW_ASSERT_ALWAYS(a_base_track, base == AW'(line * COLS), "row base out of step with row")
  `TCW_ASSERT_NEXT(a_done_loads, state == ST_DONE && !out_stall, out_valid, "result word lost")

endmodule

// ===== verif/tb.sv =====
module tb import tcw_pkg::*; ();

  localparam int COLS = COLS_DEF;
  localparam int ROWS = ROWS_DEF;
  localparam int NCELL = COLS * ROWS;
  localparam int SETTLE_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  // Shadow of the console: screen cells, cursor, scroll count and color.
  class console_shadow;
    logic [15:0] cells [NCELL];
    int col;
    int row;
    logic [SCROLL_W-1:0] scrolled;
    logic [ATTR_W-1:0] color;
    out_word_t pending_words[$];
    int mismatches;
    int words_checked;

    function new();
      for (int i = 0; i < NCELL; i++) cells[i] = '0;
      col = 0;
      row = 0;
      scrolled = '0;
      color = COLOR_RESET;
      mismatches = 0;
      words_checked = 0;
    endfunction

    function void scroll_up();
      int i;
      for (i = 0; i < NCELL - COLS; i++) cells[i] = cells[i + COLS];
      for (i = NCELL - COLS; i < NCELL; i++) cells[i] = {color, CH_SPACE};
      col = 0;
      row = ROWS - 1;
      scrolled = scrolled + 1'b1;
    endfunction

    function void next_line();
      if (row >= ROWS - 1) begin
        scroll_up();
      end else begin
        col = 0;
        row++;
      end
    endfunction

    function void put_one(logic [CHAR_W-1:0] c);
      if (col >= COLS) next_line();
      if (c == CH_LF) begin
        next_line();
        return;
      end
      if (c == CH_NUL || c == CH_CR) return;
      if (c == CH_BS) begin
        if (col == 0) begin
          if (row == 0) return;
          row--;
          col = COLS - 1;
        end else begin
          col--;
        end
        cells[row * COLS + col] = {color, CH_SPACE};
        return;
      end
      cells[row * COLS + col] = {color, c};
      col++;
    endfunction

    function void take_command(in_word_t w);
      out_word_t e;
      int r_end;
      int c_end;
      int r;
      int c;
      logic [15:0] cell_val;
      e = '0;
      case (w.command)
        CMD_PUT: begin
          if (w.char_code == CH_TAB) repeat (4) put_one(CH_SPACE);
          else put_one(w.char_code);
        end
        CMD_CLEAR: begin
          for (r = 0; r < NCELL; r++) cells[r] = {color, CH_SPACE};
          col = 0;
          row = 0;
          scrolled = '0;
        end
        CMD_BOX: begin
          c_end = (w.col_b > COLS) ? COLS : w.col_b;
          r_end = (w.row_b > ROWS) ? ROWS : w.row_b;
          for (r = w.row_a; r < r_end; r++)
            for (c = w.col_a; c < c_end; c++)
              cells[r * COLS + c][15:8] = w.fill_color;
        end
        default: begin
          if (w.col_a < COLS && w.row_a < ROWS) begin
            cell_val = cells[w.row_a * COLS + w.col_a];
            e.read_char = cell_val[7:0];
            e.read_attr = cell_val[15:8];
          end
        end
      endcase
      e.cursor_col = COL_W'(col);
      e.cursor_row = ROW_W'(row);
      e.cursor_offset = OFS_W'(row * COLS + col);
      e.scroll_count = scrolled;
      pending_words.push_back(e);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d %s: expected %0d, got %0d", words_checked, field, want, got);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result word %h arrived with nothing outstanding", got);
        return;
      end
      e = pending_words.pop_front();
      compare_field("cursor_col", 16'(e.cursor_col), 16'(got.cursor_col));
      compare_field("cursor_row", 16'(e.cursor_row), 16'(got.cursor_row));
      compare_field("cursor_offset", 16'(e.cursor_offset), 16'(got.cursor_offset));
      compare_field("read_char", 16'(e.read_char), 16'(got.read_char));
      compare_field("read_attr", 16'(e.read_attr), 16'(got.read_attr));
      compare_field("scroll_count", e.scroll_count, got.scroll_count);
      words_checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_word_t in_word;
  logic out_valid;
  logic out_stall;
  out_word_t out_word;
  logic cfg_wen;
  logic [ATTR_W-1:0] cfg_wdata;

  console_shadow sb;
  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int stuck_cycles = 0;

  text_console_writer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_word(out_word);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic in_word_t mk(cmd_t cmd, int ch, int ca, int ra, int cb, int rb, int fc);
    in_word_t w;
    w.command = cmd;
    w.char_code = CHAR_W'(ch);
    w.col_a = COL_W'(ca);
    w.row_a = ROW_W'(ra);
    w.col_b = COL_W'(cb);
    w.row_b = ROW_W'(rb);
    w.fill_color = ATTR_W'(fc);
    return w;
  endfunction

  function automatic in_word_t rand_word();
    return mk(cmd_t'($urandom_range(3)), $urandom_range(255),
              $urandom_range(COLS), $urandom_range(ROWS),
              $urandom_range(COLS), $urandom_range(ROWS), $urandom_range(255));
  endfunction

  // called and returns at a falling edge
  task automatic issue(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_word = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_command(w);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_color(input logic [ATTR_W-1:0] v);
    settle();
    cfg_wen = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_wen = 1'b0;
    sb.color = v;
  endtask

  task automatic put_char(input int ch);
    in_word_t w;
    w = rand_word();
    w.command = CMD_PUT;
    w.char_code = CHAR_W'(ch);
    issue(w);
  endtask

  task automatic text_line();
    int pick;
    int len;
    int sel;
    pick = $urandom_range(99);
    if (pick < 50) len = $urandom_range(8);
    else if (pick < 85) len = $urandom_range(60, 9);
    else len = $urandom_range(90, 70);
    repeat (len) begin
      sel = $urandom_range(99);
      if (sel < 88) put_char($urandom_range(8'h7E, 8'h20));
      else if (sel < 91) put_char($urandom_range(255));
      else if (sel < 95) put_char(CH_BS);
      else if (sel < 98) put_char(CH_TAB);
      else put_char($urandom_range(1) ? CH_NUL : CH_CR);
    end
    if ($urandom_range(99) < 70) put_char(CH_LF);
  endtask

  task automatic box_fill();
    in_word_t w;
    int ca;
    int ra;
    w = rand_word();
    w.command = CMD_BOX;
    if ($urandom_range(99) < 80) begin
      ca = $urandom_range(COLS - 1);
      ra = $urandom_range(ROWS - 1);
      w.col_a = COL_W'(ca);
      w.row_a = ROW_W'(ra);
      ca = ca + $urandom_range(6);
      ra = ra + $urandom_range(3);
      w.col_b = COL_W'((ca > COLS) ? COLS : ca);
      w.row_b = ROW_W'((ra > ROWS) ? ROWS : ra);
    end
    issue(w);
  endtask

  task automatic run_traffic(input int target);
    int kind;
    in_word_t w;
    items_sent = 0;
    while (items_sent < target) begin
      kind = $urandom_range(99);
      if (kind < 50) begin
        text_line();
      end else if (kind < 65) begin
        repeat ($urandom_range(6, 1)) put_char(CH_LF);
      end else if (kind < 75) begin
        box_fill();
      end else if (kind < 90) begin
        repeat ($urandom_range(3, 1)) begin
          w = rand_word();
          w.command = CMD_READ;
          issue(w);
        end
      end else if (kind < 92) begin
        w = rand_word();
        w.command = CMD_CLEAR;
        issue(w);
      end else begin
        repeat ($urandom_range(4, 1)) issue(rand_word());
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    items_sent = 0;
    send_idle_pct = 26;
    recv_idle_pct = 72;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_color(8'hFF);
    // screen store is undefined until the first clear
    issue(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    issue(mk(CMD_PUT, 8'h41, 0, 0, 0, 0, 0));
    issue(mk(CMD_PUT, 8'hFF, COLS, ROWS, COLS, ROWS, 8'hFF));
    issue(mk(CMD_PUT, CH_TAB, 0, 0, 0, 0, 0));
    issue(mk(CMD_PUT, CH_BS, 0, 0, 0, 0, 0));
    issue(mk(CMD_PUT, CH_NUL, 0, 0, 0, 0, 0));
    issue(mk(CMD_PUT, CH_CR, 0, 0, 0, 0, 0));
    issue(mk(CMD_PUT, CH_LF, 0, 0, 0, 0, 0));
    // backspace at column 0 goes to the end of the row above
    issue(mk(CMD_PUT, CH_BS, 0, 0, 0, 0, 0));
    issue(mk(CMD_READ, 0, COLS - 1, 0, 0, 0, 0));
    issue(mk(CMD_READ, 0, 0, 0, 0, 0, 0));
    issue(mk(CMD_READ, 0, COLS, 0, 0, 0, 0));
    issue(mk(CMD_READ, 0, 0, ROWS, 0, 0, 0));
    issue(mk(CMD_BOX, 0, 0, 0, COLS, ROWS, 8'hFF));
    issue(mk(CMD_BOX, 0, 10, 5, 3, 2, 8'h00));
    issue(mk(CMD_BOX, 0, 5, 5, 5, 9, 8'h11));
    issue(mk(CMD_READ, 0, COLS - 1, ROWS - 1, 0, 0, 0));
    write_color(8'h00);
    issue(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
    // backspace at the origin does nothing
    issue(mk(CMD_PUT, CH_BS, 0, 0, 0, 0, 0));
    issue(mk(CMD_PUT, 8'h7F, 0, 0, 0, 0, 0));
    issue(mk(CMD_READ, 0, 0, 0, 0, 0, 0));
    issue(mk(CMD_READ, 0, 1, 0, 0, 0, 0));

    write_color(ATTR_W'($urandom_range(254, 1)));
    run_traffic(320);

    send_idle_pct = 72;
    recv_idle_pct = 26;
    write_color(8'h80);
    run_traffic(320);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_color(ATTR_W'($urandom_range(255)));
    run_traffic(310);

    settle();
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
